FILE: rtl/mhe_pkg.sv
// Package for the half-ellipse midpoint point generator.
// Widths, reset values, register indexes, state and datapath command types.
// Used by every module under rtl/.
package mhe_pkg;

    localparam int COORD_BITS     = 13;
    localparam int CENTER_BITS    = 12;
    localparam int RX_BITS        = 5;
    localparam int RY_BITS        = 6;
    localparam int CFG_DATA_BITS  = 6;
    localparam int CFG_INDEX_BITS = 1;
    localparam int RX2_BITS       = 10;
    localparam int RY2_BITS       = 12;
    localparam int MAX_POINTS     = 64;
    localparam int N_BITS         = 7;
    localparam int X_BITS         = 7;
    localparam int Y_BITS         = 6;
    localparam int T_BITS         = X_BITS + 1;
    localparam int DX_BITS        = 19;
    localparam int DY_BITS        = 17;
    localparam int SQ_BITS        = 15;
    localparam int P_BITS         = 32;

    localparam logic [RX_BITS-1:0] RADIUS_X_RESET = RX_BITS'(18);
    localparam logic [RY_BITS-1:0] RADIUS_Y_RESET = RY_BITS'(41);

    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS_X = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS_Y = CFG_INDEX_BITS'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_INIT1,
        ST_STEP1,
        ST_T_SQ,
        ST_P_RY,
        ST_Y_SQ,
        ST_P_RX,
        ST_P_RXRY,
        ST_STEP2
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQ_RX,
        OP_SQ_RY,
        OP_INIT1,
        OP_STEP1,
        OP_T_SQ,
        OP_P_RY,
        OP_Y_SQ,
        OP_P_RX,
        OP_P_RXRY,
        OP_STEP2
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic radius_zero;
        logic out_free;
        logic last_r1;
        logic last_r2;
        logic leave_r1;
    } dp_status_t;

endpackage

FILE: rtl/mhe_controller.sv
// Sequencer for the half-ellipse point generator.
// Issues datapath commands from the state machine; types from mhe_pkg.
module mhe_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mhe_pkg::dp_status_t status,
    output mhe_pkg::dp_cmd_t    cmd
);

    mhe_pkg::state_t state_reg;
    mhe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mhe_pkg::OP_NOP;
        in_stall   = 1'b1;
        case (state_reg)
            mhe_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = mhe_pkg::OP_LOAD;
                    if (!status.radius_zero)
                    begin
                        state_next = mhe_pkg::ST_SQ_RX;
                    end
                end
            end
            mhe_pkg::ST_SQ_RX:
            begin
                cmd.op     = mhe_pkg::OP_SQ_RX;
                state_next = mhe_pkg::ST_SQ_RY;
            end
            mhe_pkg::ST_SQ_RY:
            begin
                cmd.op     = mhe_pkg::OP_SQ_RY;
                state_next = mhe_pkg::ST_INIT1;
            end
            mhe_pkg::ST_INIT1:
            begin
                cmd.op     = mhe_pkg::OP_INIT1;
                state_next = mhe_pkg::ST_STEP1;
            end
            mhe_pkg::ST_STEP1:
            begin
                if (status.out_free)
                begin
                    cmd.op = mhe_pkg::OP_STEP1;
                    if (status.last_r1)
                    begin
                        state_next = mhe_pkg::ST_IDLE;
                    end
                    else if (status.leave_r1)
                    begin
                        state_next = mhe_pkg::ST_T_SQ;
                    end
                end
            end
            mhe_pkg::ST_T_SQ:
            begin
                cmd.op     = mhe_pkg::OP_T_SQ;
                state_next = mhe_pkg::ST_P_RY;
            end
            mhe_pkg::ST_P_RY:
            begin
                cmd.op     = mhe_pkg::OP_P_RY;
                state_next = mhe_pkg::ST_Y_SQ;
            end
            mhe_pkg::ST_Y_SQ:
            begin
                cmd.op     = mhe_pkg::OP_Y_SQ;
                state_next = mhe_pkg::ST_P_RX;
            end
            mhe_pkg::ST_P_RX:
            begin
                cmd.op     = mhe_pkg::OP_P_RX;
                state_next = mhe_pkg::ST_P_RXRY;
            end
            mhe_pkg::ST_P_RXRY:
            begin
                cmd.op     = mhe_pkg::OP_P_RXRY;
                state_next = mhe_pkg::ST_STEP2;
            end
            mhe_pkg::ST_STEP2:
            begin
                if (status.out_free)
                begin
                    cmd.op = mhe_pkg::OP_STEP2;
                    if (status.last_r2)
                    begin
                        state_next = mhe_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = mhe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mhe_datapath.sv
// Datapath of the half-ellipse point generator: radius registers, decision
// and increment registers, one multiplier per setup op, output register.
// Depends on mhe_pkg.
module mhe_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write_en,
    input  logic [mhe_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [mhe_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic signed [mhe_pkg::CENTER_BITS-1:0]   center_x,
    input  logic signed [mhe_pkg::CENTER_BITS-1:0]   center_y,
    input  mhe_pkg::dp_cmd_t                         cmd,
    output mhe_pkg::dp_status_t                      status,
    input  logic                                     out_stall,
    output logic                                     out_valid,
    output logic signed [mhe_pkg::COORD_BITS-1:0]    point_x,
    output logic signed [mhe_pkg::COORD_BITS-1:0]    point_y_upper,
    output logic signed [mhe_pkg::COORD_BITS-1:0]    point_y_lower,
    output logic                                     last
);

    localparam int PB = mhe_pkg::P_BITS;
    localparam int CB = mhe_pkg::COORD_BITS;

    logic [mhe_pkg::RX_BITS-1:0]              radius_x_reg;
    logic [mhe_pkg::RY_BITS-1:0]              radius_y_reg;
    logic signed [mhe_pkg::CENTER_BITS-1:0]   cx_reg;
    logic signed [mhe_pkg::CENTER_BITS-1:0]   cy_reg;
    logic [mhe_pkg::RX2_BITS-1:0]             rx2_reg, rx2_next;
    logic [mhe_pkg::RY2_BITS-1:0]             ry2_reg, ry2_next;
    logic [mhe_pkg::X_BITS-1:0]               x_reg, x_next;
    logic [mhe_pkg::Y_BITS-1:0]               y_reg, y_next;
    logic [mhe_pkg::N_BITS-1:0]               n_reg, n_next;
    logic [mhe_pkg::DX_BITS-1:0]              dx_reg, dx_next;
    logic [mhe_pkg::DY_BITS-1:0]              dy_reg, dy_next;
    logic [mhe_pkg::SQ_BITS-1:0]              sq_reg, sq_next;
    logic signed [PB-1:0]                     p_reg, p_next;
    logic                                     out_valid_reg, out_valid_next;
    logic signed [CB-1:0]                     point_x_reg, point_y_upper_reg;
    logic signed [CB-1:0]                     point_y_lower_reg;
    logic                                     last_reg;

    // step candidates for both regions
    logic [mhe_pkg::X_BITS-1:0]  x1, x2;
    logic [mhe_pkg::Y_BITS-1:0]  y1, y2;
    logic [mhe_pkg::DX_BITS-1:0] dx1, dx2, dx_inc;
    logic [mhe_pkg::DY_BITS-1:0] dy1, dy2, dy_dec;
    logic signed [PB-1:0]        p1, p2, d1, d2;
    logic signed [PB-1:0]        rx2s, ry2s, dx1s, dy1s, dx2s, dy2s;
    logic                        dec1, inc2, cont1, cap;
    logic [mhe_pkg::N_BITS-1:0]  n_inc;
    logic [mhe_pkg::T_BITS-1:0]  t_val;
    logic [mhe_pkg::Y_BITS-1:0]  y_m1;
    logic signed [PB-1:0]        mul_rxry;
    logic                        is_step, is_step2;
    logic [mhe_pkg::X_BITS-1:0]  x_out;
    logic [mhe_pkg::Y_BITS-1:0]  y_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x_reg  <= mhe_pkg::RADIUS_X_RESET;
            radius_y_reg  <= mhe_pkg::RADIUS_Y_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en && (cfg_index == mhe_pkg::REG_RADIUS_X))
            begin
                radius_x_reg <= cfg_data[mhe_pkg::RX_BITS-1:0];
            end
            if (cfg_write_en && (cfg_index == mhe_pkg::REG_RADIUS_Y))
            begin
                radius_y_reg <= cfg_data[mhe_pkg::RY_BITS-1:0];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == mhe_pkg::OP_LOAD)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
        end
        rx2_reg <= rx2_next;
        ry2_reg <= ry2_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        n_reg   <= n_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sq_reg  <= sq_next;
        p_reg   <= p_next;
        if (is_step)
        begin
            point_x_reg       <= CB'(cx_reg) + CB'(x_out);
            point_y_upper_reg <= CB'(cy_reg) + CB'(y_out);
            point_y_lower_reg <= CB'(cy_reg) - CB'(y_out);
            last_reg          <= is_step2 ? status.last_r2 : status.last_r1;
        end
    end

    assign rx2s   = PB'(rx2_reg);
    assign ry2s   = PB'(ry2_reg);
    assign dx_inc = dx_reg + mhe_pkg::DX_BITS'({ry2_reg, 1'b0});
    assign dy_dec = dy_reg - mhe_pkg::DY_BITS'({rx2_reg, 1'b0});
    assign n_inc  = n_reg + 1'b1;
    assign cap    = (n_inc == mhe_pkg::N_BITS'(mhe_pkg::MAX_POINTS));

    // region one: x always moves, y moves when the decision is not negative
    always_comb
    begin
        dec1  = !(p_reg < 0);
        x1    = x_reg + 1'b1;
        dx1   = dx_inc;
        y1    = dec1 ? y_reg - 1'b1 : y_reg;
        dy1   = dec1 ? dy_dec : dy_reg;
        dx1s  = PB'(dx1);
        dy1s  = PB'(dy1);
        d1    = dec1 ? (dx1s - dy1s + ry2s) : (dx1s + ry2s);
        p1    = p_reg + (d1 <<< 2);
        cont1 = (mhe_pkg::DX_BITS'(dx1) <= mhe_pkg::DX_BITS'(dy1));
    end

    // region two: y always moves, x moves when the decision is not positive
    always_comb
    begin
        inc2 = !(p_reg > 0);
        y2   = y_reg - 1'b1;
        dy2  = dy_dec;
        x2   = inc2 ? x_reg + 1'b1 : x_reg;
        dx2  = inc2 ? dx_inc : dx_reg;
        dx2s = PB'(dx2);
        dy2s = PB'(dy2);
        d2   = inc2 ? (dx2s - dy2s + rx2s) : (rx2s - dy2s);
        p2   = p_reg + (d2 <<< 2);
    end

    assign status.radius_zero = (radius_x_reg == '0) || (radius_y_reg == '0);
    assign status.out_free    = !out_valid_reg || !out_stall;
    assign status.leave_r1    = !cont1;
    assign status.last_r1     = cap || (!cont1 && (y1 == '0));
    assign status.last_r2     = cap || (y2 == '0);

    assign is_step2 = (cmd.op == mhe_pkg::OP_STEP2);
    assign is_step  = (cmd.op == mhe_pkg::OP_STEP1) || is_step2;
    assign x_out    = is_step2 ? x2 : x1;
    assign y_out    = is_step2 ? y2 : y1;
    assign t_val    = {x_reg, 1'b1};
    assign y_m1     = y_reg - 1'b1;
    assign mul_rxry = PB'(rx2_reg) * PB'(radius_y_reg);

    always_comb
    begin
        rx2_next = rx2_reg;
        ry2_next = ry2_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        n_next   = n_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        sq_next  = sq_reg;
        p_next   = p_reg;
        case (cmd.op)
            mhe_pkg::OP_SQ_RX:
            begin
                rx2_next = mhe_pkg::RX2_BITS'(radius_x_reg)
                         * mhe_pkg::RX2_BITS'(radius_x_reg);
            end
            mhe_pkg::OP_SQ_RY:
            begin
                ry2_next = mhe_pkg::RY2_BITS'(radius_y_reg)
                         * mhe_pkg::RY2_BITS'(radius_y_reg);
            end
            mhe_pkg::OP_INIT1:
            begin
                x_next  = '0;
                y_next  = radius_y_reg;
                n_next  = '0;
                dx_next = '0;
                dy_next = mhe_pkg::DY_BITS'(mul_rxry <<< 1);
                p_next  = (ry2s <<< 2) - (mul_rxry <<< 2) + rx2s;
            end
            mhe_pkg::OP_STEP1:
            begin
                x_next  = x1;
                y_next  = y1;
                dx_next = dx1;
                dy_next = dy1;
                p_next  = p1;
                n_next  = n_inc;
            end
            mhe_pkg::OP_T_SQ:
            begin
                sq_next = mhe_pkg::SQ_BITS'(t_val) * mhe_pkg::SQ_BITS'(t_val);
            end
            mhe_pkg::OP_P_RY:
            begin
                p_next = ry2s * PB'(sq_reg);
            end
            mhe_pkg::OP_Y_SQ:
            begin
                sq_next = mhe_pkg::SQ_BITS'(y_m1) * mhe_pkg::SQ_BITS'(y_m1);
            end
            mhe_pkg::OP_P_RX:
            begin
                p_next = p_reg + ((rx2s * PB'(sq_reg)) <<< 2);
            end
            mhe_pkg::OP_P_RXRY:
            begin
                p_next = p_reg - ((rx2s * ry2s) <<< 2);
            end
            mhe_pkg::OP_STEP2:
            begin
                x_next  = x2;
                y_next  = y2;
                dx_next = dx2;
                dy_next = dy2;
                p_next  = p2;
                n_next  = n_inc;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (is_step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = point_x_reg;
    assign point_y_upper = point_y_upper_reg;
    assign point_y_lower = point_y_lower_reg;
    assign last          = last_reg;

endmodule

FILE: rtl/midpoint_half_ellipse_points.sv
// Top level of the half-ellipse midpoint point generator.
// Instantiates mhe_controller and mhe_datapath; types from mhe_pkg.
//
// Usage: the input channel takes one ellipse center per transfer; the radii
// come from the two configuration registers, to be written only while idle by
// the user; the block does not enforce this. Each center yields up to 64 output
// transfers, one per step of the right half walk, with last set on the final one.
// Setup: after the input transfer the radii are squared and the first decision
// is formed before the first result is registered. The sequencer handles one
// item at a time. The second-region decision is formed in the states T_SQ,
// P_RY, Y_SQ, P_RX and P_RXRY; they are skipped when the walk ends in region
// one (y reaches zero or the 64 result cap). Zero radius yields nothing. The
// next center is taken once the final step is issued.
// Stall: a stalled result holds in the output register; the walk pauses
// while the output register is full and stalled.
// Reset: radii return to 18 and 41, no result is pending.
module midpoint_half_ellipse_points (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [mhe_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mhe_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [mhe_pkg::CENTER_BITS-1:0] center_x,
    input  logic signed [mhe_pkg::CENTER_BITS-1:0] center_y,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [mhe_pkg::COORD_BITS-1:0]  point_x,
    output logic signed [mhe_pkg::COORD_BITS-1:0]  point_y_upper,
    output logic signed [mhe_pkg::COORD_BITS-1:0]  point_y_lower,
    output logic                                   last
);

    mhe_pkg::dp_cmd_t    cmd;
    mhe_pkg::dp_status_t status;

    mhe_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mhe_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .center_x      (center_x),
        .center_y      (center_y),
        .cmd           (cmd),
        .status        (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .point_x       (point_x),
        .point_y_upper (point_y_upper),
        .point_y_lower (point_y_lower),
        .last          (last)
    );

endmodule

FILE: rtl/mhe_checker.sv
// Port-level checks for midpoint_half_ellipse_points, attached by bind.
// Tracks the previous result transfer of the same ellipse; uses mhe_pkg.
module mhe_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [mhe_pkg::COORD_BITS-1:0]  point_x,
    input logic signed [mhe_pkg::COORD_BITS-1:0]  point_y_upper,
    input logic signed [mhe_pkg::COORD_BITS-1:0]  point_y_lower,
    input logic                                   last
);

    localparam int CB = mhe_pkg::COORD_BITS;

    logic          open_reg;
    logic [CB-1:0] prev_x_reg;
    logic [CB-1:0] prev_up_reg;
    logic [CB-1:0] prev_sum_reg;
    logic [CB-1:0] sum_y;
    logic [CB-1:0] step_x;
    logic [CB-1:0] step_y;
    logic          xfer;

    assign xfer   = out_valid && !out_stall;
    assign sum_y  = point_y_upper + point_y_lower;
    assign step_x = point_x - prev_x_reg;
    assign step_y = prev_up_reg - point_y_upper;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            prev_x_reg   <= '0;
            prev_up_reg  <= '0;
            prev_sum_reg <= '0;
        end
        else if (xfer)
        begin
            open_reg     <= !last;
            prev_x_reg   <= point_x;
            prev_up_reg  <= point_y_upper;
            prev_sum_reg <= sum_y;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_x)
            && $stable(point_y_upper) && $stable(point_y_lower) && $stable(last))
        else $error("stalled result changed");

    // rows stay mirrored about one center within an ellipse
    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && open_reg |-> sum_y == prev_sum_reg)
        else $error("row pair not mirrored about the same center");

    // each step moves right by at most one pixel and down by at most one
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && open_reg |-> (step_x == CB'(0) || step_x == CB'(1))
            && (step_y == CB'(0) || step_y == CB'(1))
            && !(step_x == CB'(0) && step_y == CB'(0)))
        else $error("walk step out of range");

endmodule

bind midpoint_half_ellipse_points mhe_checker u_mhe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .point_x       (point_x),
    .point_y_upper (point_y_upper),
    .point_y_lower (point_y_lower),
    .last          (last)
);
